FILE: sv/atrpp_pkg.sv
// Package for the AT response parameter parser.
// Holds the parser phase and result kind types, error codes and character constants.
// Used by at_response_param_parser; depends on nothing else.
package atrpp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SKIP  = 3'd1,
		PH_READY = 3'd2,
		PH_INT   = 3'd3,
		PH_STR   = 3'd4,
		PH_AFTER = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_STR_CHAR  = 3'd0,
		K_EMPTY     = 3'd1,
		K_INT       = 3'd2,
		K_STR_DONE  = 3'd3,
		K_DONE      = 3'd4,
		K_ERROR     = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		E_NONE         = 4'd0,
		E_DOUBLE_SPACE = 4'd1,
		E_BAD_READY    = 4'd2,
		E_BAD_AFTER    = 4'd3,
		E_NONPRINT     = 4'd4,
		E_SIGN_COMMA   = 4'd5,
		E_SIGN_END     = 4'd6,
		E_BAD_INT      = 4'd7,
		E_OVERFLOW     = 4'd8
	} err_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	// Integer magnitudes saturate here; the negative limit needs exactly this value.
	localparam logic [31:0] MAG_CAP = 32'h8000_0000;
	localparam logic [31:0] INT_POS_MAX = 32'h7FFF_FFFF;

endpackage

FILE: sv/at_response_param_parser.sv
// AT response parameter parser, top level.
// Depends on atrpp_pkg for phase, result kind and error code definitions.
//
// Usage: an input beat carries op and char_in on the in channel. op = 1 starts a
// new response line and clears the parameter index; op = 0 carries one character.
// Characters up to the first space are skipped; after it the line is split at
// commas into empty, signed decimal integer and quoted string parameters. Each
// string character, each finished parameter, the end of the line and any error
// give one result beat on the out channel; other input beats give none. A beat
// with last = 1 ends the response and the parser ignores characters until the
// next start beat.
// The input register is loaded when a beat is accepted, and the result register is
// loaded from it once the receiver does not stall; the result is then on out_valid.
// Throughput: one input beat per cycle unless the receiver stalls; every character
// needs only one state update and one multiply-by-ten add, done between the two
// registers. When the receiver stalls, the result register holds its beat and the
// input register holds one more; in_stall rises once both are full.
// Reset clears both registers and returns the parser to idle, waiting for start.
module at_response_param_parser #(
	parameter int MAX_PARAMS = 16,
	parameter int TOKEN_MAX  = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [7:0]         char_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [3:0]         param_index,
	output logic signed [31:0] param_value,
	output logic [7:0]         str_char,
	output logic [6:0]         char_pos,
	output logic [7:0]         str_len,
	output logic               last,
	output logic [4:0]         param_count,
	output logic [3:0]         error_code
);
	import atrpp_pkg::*;

	localparam int PW = $clog2(MAX_PARAMS + 1);
	localparam int TW = $clog2(TOKEN_MAX + 1);

	// Input register.
	logic       s1_valid_q;
	logic       op_s1;
	logic [7:0] char_s1;

	// Parser state.
	phase_t         phase_q, phase_nxt;
	logic [PW-1:0]  param_idx_q, param_idx_nxt;
	logic [TW-1:0]  token_len_q, token_len_nxt;
	logic [31:0]    mag_q, mag_nxt;
	logic           neg_q, neg_nxt;
	logic           seen_q, seen_nxt;

	// Result register.
	logic        out_valid_q;
	kind_t       kind_q;
	logic [3:0]  param_index_q;
	logic [31:0] param_value_q;
	logic [7:0]  str_char_q;
	logic [6:0]  char_pos_q;
	logic [7:0]  str_len_q;
	logic        last_q;
	logic [4:0]  param_count_q;
	err_t        error_code_q;

	// Result of the current beat.
	logic        res_vld;
	kind_t       res_kind;
	logic [3:0]  res_idx;
	logic [31:0] res_ival;
	logic [7:0]  res_ch;
	logic [6:0]  res_pos;
	logic [7:0]  res_len;
	logic        res_last;
	logic [4:0]  res_cnt;
	err_t        res_err;

	logic        adv;
	logic        step;
	logic        is_dig, is_end_c, is_start, is_print;
	logic        idx_full, tok_full;
	logic [7:0]  idx8, tok8;
	logic [35:0] mag_x10;
	logic [31:0] mag_sat;
	logic [31:0] int_res;

	assign adv      = !out_valid_q || !out_stall;
	assign step     = s1_valid_q && adv;
	assign in_stall = s1_valid_q && !adv;

	assign is_dig   = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_end_c = (char_s1 == CH_NUL) || (char_s1 == CH_CR) || (char_s1 == CH_LF);
	assign is_start = (char_s1 == CH_COMMA) || (char_s1 == CH_QUOTE) ||
		(char_s1 == CH_PLUS) || (char_s1 == CH_MINUS) || is_dig;
	assign is_print = (char_s1 >= PRINT_LO) && (char_s1 <= PRINT_HI);
	assign idx_full = param_idx_q >= PW'(MAX_PARAMS);
	assign tok_full = token_len_q >= TW'(TOKEN_MAX);
	assign idx8     = 8'(param_idx_q);
	assign tok8     = 8'(token_len_q);

	// Decimal accumulate: m * 10 + digit, saturating at the magnitude cap.
	assign mag_x10 = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {32'd0, char_s1[3:0]};
	assign mag_sat = (mag_x10 > {4'd0, MAG_CAP}) ? MAG_CAP : mag_x10[31:0];
	assign int_res = neg_q ? (32'd0 - mag_q) : (mag_q[31] ? INT_POS_MAX : mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!s1_valid_q || adv) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			char_s1 <= char_in;
		end
	end

	// Next state.
	always_comb begin
		phase_nxt     = phase_q;
		param_idx_nxt = param_idx_q;
		token_len_nxt = token_len_q;
		mag_nxt       = mag_q;
		neg_nxt       = neg_q;
		seen_nxt      = seen_q;
		if (op_s1) begin
			phase_nxt     = PH_SKIP;
			param_idx_nxt = '0;
			token_len_nxt = '0;
			mag_nxt       = '0;
			neg_nxt       = 1'b0;
			seen_nxt      = 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_SKIP: begin
					if (char_s1 == CH_NUL) begin
						phase_nxt = PH_IDLE;
					end else if (char_s1 == CH_SPACE) begin
						phase_nxt = PH_READY;
					end
				end
				PH_READY: begin
					if (is_end_c || char_s1 == CH_SPACE || !is_start || idx_full) begin
						phase_nxt = PH_IDLE;
					end else if (char_s1 == CH_COMMA) begin
						param_idx_nxt = param_idx_q + PW'(1);
					end else if (char_s1 == CH_QUOTE) begin
						token_len_nxt = '0;
						mag_nxt       = '0;
						neg_nxt       = 1'b0;
						seen_nxt      = 1'b0;
						phase_nxt     = PH_STR;
					end else begin
						// The sign or first digit counts as the first token character.
						token_len_nxt = TW'(1);
						mag_nxt       = is_dig ? {28'd0, char_s1[3:0]} : 32'd0;
						neg_nxt       = (char_s1 == CH_MINUS);
						seen_nxt      = is_dig;
						phase_nxt     = PH_INT;
					end
				end
				PH_AFTER: begin
					if (char_s1 == CH_COMMA && !is_end_c) begin
						phase_nxt = PH_READY;
					end else begin
						phase_nxt = PH_IDLE;
					end
				end
				PH_STR: begin
					if (char_s1 == CH_QUOTE) begin
						param_idx_nxt = param_idx_q + PW'(1);
						token_len_nxt = '0;
						phase_nxt     = PH_AFTER;
					end else if (!is_print || tok_full) begin
						phase_nxt = PH_IDLE;
					end else begin
						token_len_nxt = token_len_q + TW'(1);
					end
				end
				PH_INT: begin
					if (char_s1 == CH_COMMA || is_end_c) begin
						if (seen_q) begin
							param_idx_nxt = param_idx_q + PW'(1);
							token_len_nxt = '0;
						end
						phase_nxt = (seen_q && char_s1 == CH_COMMA) ? PH_READY : PH_IDLE;
					end else if (!is_dig || tok_full) begin
						phase_nxt = PH_IDLE;
					end else begin
						mag_nxt       = mag_sat;
						seen_nxt      = 1'b1;
						token_len_nxt = token_len_q + TW'(1);
					end
				end
				default: begin
					phase_nxt = PH_IDLE;
				end
			endcase
		end
	end

	// Result of the beat in the input register.
	always_comb begin
		res_vld  = 1'b0;
		res_kind = K_STR_CHAR;
		res_idx  = idx8[3:0];
		res_ival = '0;
		res_ch   = '0;
		res_pos  = '0;
		res_len  = '0;
		res_last = 1'b0;
		res_cnt  = '0;
		res_err  = E_NONE;
		if (!op_s1) begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_SKIP: begin
					if (char_s1 == CH_NUL) begin
						res_vld  = 1'b1;
						res_kind = K_DONE;
						res_idx  = '0;
						res_last = 1'b1;
						res_cnt  = idx8[4:0];
					end
				end
				PH_READY: begin
					res_vld = 1'b1;
					if (is_end_c) begin
						res_kind = K_DONE;
						res_idx  = '0;
						res_last = 1'b1;
						res_cnt  = idx8[4:0];
					end else if (char_s1 == CH_SPACE) begin
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_DOUBLE_SPACE;
					end else if (!is_start) begin
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_BAD_READY;
					end else if (idx_full) begin
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_OVERFLOW;
					end else if (char_s1 == CH_COMMA) begin
						res_kind = K_EMPTY;
					end else begin
						res_vld = 1'b0;
					end
				end
				PH_AFTER: begin
					if (is_end_c) begin
						res_vld  = 1'b1;
						res_kind = K_DONE;
						res_idx  = '0;
						res_last = 1'b1;
						res_cnt  = idx8[4:0];
					end else if (char_s1 != CH_COMMA) begin
						res_vld  = 1'b1;
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_BAD_AFTER;
					end
				end
				PH_STR: begin
					res_vld = 1'b1;
					if (char_s1 == CH_QUOTE) begin
						res_kind = K_STR_DONE;
						res_len  = tok8;
					end else if (!is_print) begin
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_NONPRINT;
					end else if (tok_full) begin
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_OVERFLOW;
					end else begin
						res_kind = K_STR_CHAR;
						res_ch   = char_s1;
						res_pos  = tok8[6:0];
					end
				end
				PH_INT: begin
					res_vld = 1'b1;
					if (char_s1 == CH_COMMA || is_end_c) begin
						if (!seen_q) begin
							res_kind = K_ERROR;
							res_last = 1'b1;
							res_err  = (char_s1 == CH_COMMA) ? E_SIGN_COMMA : E_SIGN_END;
						end else begin
							res_kind = K_INT;
							res_ival = int_res;
							// An integer that ends the line also closes the response.
							if (is_end_c) begin
								res_last = 1'b1;
								res_cnt  = 5'(idx8 + 8'd1);
							end
						end
					end else if (!is_dig) begin
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_BAD_INT;
					end else if (tok_full) begin
						res_kind = K_ERROR;
						res_last = 1'b1;
						res_err  = E_OVERFLOW;
					end else begin
						res_vld = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			param_idx_q <= '0;
			token_len_q <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_nxt;
			param_idx_q <= param_idx_nxt;
			token_len_q <= token_len_nxt;
			mag_q       <= mag_nxt;
			neg_q       <= neg_nxt;
			seen_q      <= seen_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_vld) begin
			kind_q        <= res_kind;
			param_index_q <= res_idx;
			param_value_q <= res_ival;
			str_char_q    <= res_ch;
			char_pos_q    <= res_pos;
			str_len_q     <= res_len;
			last_q        <= res_last;
			param_count_q <= res_cnt;
			error_code_q  <= res_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign param_index = param_index_q;
	assign param_value = param_value_q;
	assign str_char    = str_char_q;
	assign char_pos    = char_pos_q;
	assign str_len     = str_len_q;
	assign last        = last_q;
	assign param_count = param_count_q;
	assign error_code  = error_code_q;

	// An error code is reported exactly on error beats.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((kind_q == K_ERROR) == (error_code_q != E_NONE)))
		else $error("error code does not match result kind");

	// Only done, error and a line-ending integer close a response.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (kind_q == K_DONE || kind_q == K_ERROR || kind_q == K_INT))
		else $error("last set on a beat that cannot end a response");

	// A closing beat always leaves the parser idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_vld && res_last && !op_s1) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after a closing beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(param_idx_q <= PW'(MAX_PARAMS)) && (token_len_q <= TW'(TOKEN_MAX)))
		else $error("parameter index or token length beyond its limit");

endmodule

FILE: tb/sv/at_response_param_parser_test.sv
`timescale 1ns / 100ps
// Testbench for at_response_param_parser: sends response lines as input beats and
// checks every result beat against an in-bench model of the parser.
// Depends on atrpp_pkg and the at_response_param_parser RTL.
module at_response_param_parser_test;
	import atrpp_pkg::*;

	localparam int MAX_PARAMS = 16;
	localparam int TOKEN_MAX  = 128;

	typedef struct packed {
		kind_t              kind;
		logic [3:0]         param_index;
		logic signed [31:0] param_value;
		logic [7:0]         str_char;
		logic [6:0]         char_pos;
		logic [7:0]         str_len;
		logic               last;
		logic [4:0]         param_count;
		err_t               error_code;
	} parse_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               op = 1'b0;
	logic [7:0]         char_in = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         kind;
	logic [3:0]         param_index;
	logic signed [31:0] param_value;
	logic [7:0]         str_char;
	logic [6:0]         char_pos;
	logic [7:0]         str_len;
	logic               last;
	logic [4:0]         param_count;
	logic [3:0]         error_code;

	// Parser model state.
	phase_t      line_phase = PH_IDLE;
	int          param_num = 0;
	int          tok_len = 0;
	logic [31:0] mag = '0;
	logic        neg = 1'b0;
	logic        digit_seen = 1'b0;

	parse_result_t pending_results[$];
	int            error_count = 0;
	int            beats_sent = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;
	int            hold_cycles = 0;

	at_response_param_parser #(
		.MAX_PARAMS(MAX_PARAMS),
		.TOKEN_MAX(TOKEN_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.param_index(param_index),
		.param_value(param_value),
		.str_char(str_char),
		.char_pos(char_pos),
		.str_len(str_len),
		.last(last),
		.param_count(param_count),
		.error_code(error_code)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic parse_result_t blank_result(kind_t k);
		parse_result_t r;
		r = '0;
		r.kind = k;
		r.param_index = param_num[3:0];
		r.error_code = E_NONE;
		return r;
	endfunction

	function automatic void fail_line(err_t e);
		parse_result_t r;
		r = blank_result(K_ERROR);
		r.last = 1'b1;
		r.error_code = e;
		pending_results.push_back(r);
		line_phase = PH_IDLE;
	endfunction

	function automatic void close_line();
		parse_result_t r;
		r = blank_result(K_DONE);
		r.param_index = '0;
		r.last = 1'b1;
		r.param_count = param_num[4:0];
		pending_results.push_back(r);
		line_phase = PH_IDLE;
	endfunction

	// Magnitude saturates just past the positive limit so that the most negative
	// value still comes out exact.
	function automatic void add_digit(logic [7:0] c);
		logic [35:0] m;
		m = {4'b0, mag} * 36'd10 + {28'b0, c - CH_ZERO};
		mag = (m > {4'b0, MAG_CAP}) ? MAG_CAP : m[31:0];
		digit_seen = 1'b1;
	endfunction

	function automatic logic [31:0] int_result_of();
		if (neg)
			return 32'd0 - mag;
		return (mag > INT_POS_MAX) ? INT_POS_MAX : mag;
	endfunction

	// Advances the model by one accepted beat and queues the result it causes.
	function automatic void parse_char(logic is_start, logic [7:0] c);
		parse_result_t r;
		logic          is_end;
		logic          is_dig;
		r = blank_result(K_STR_CHAR);
		is_end = (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		if (is_start) begin
			line_phase = PH_SKIP;
			param_num = 0;
			tok_len = 0;
			mag = '0;
			neg = 1'b0;
			digit_seen = 1'b0;
			return;
		end
		case (line_phase)
		PH_SKIP: begin
			if (c == CH_NUL)
				close_line();
			else if (c == CH_SPACE)
				line_phase = PH_READY;
		end
		PH_READY: begin
			if (is_end) begin
				close_line();
			end else if (c == CH_SPACE) begin
				fail_line(E_DOUBLE_SPACE);
			end else if (c == CH_COMMA || c == CH_QUOTE || c == CH_PLUS || c == CH_MINUS
					|| is_dig) begin
				if (param_num >= MAX_PARAMS) begin
					fail_line(E_OVERFLOW);
				end else if (c == CH_COMMA) begin
					r.kind = K_EMPTY;
					pending_results.push_back(r);
					param_num++;
				end else begin
					tok_len = 0;
					mag = '0;
					neg = (c == CH_MINUS);
					digit_seen = 1'b0;
					if (c == CH_QUOTE) begin
						line_phase = PH_STR;
					end else begin
						if (is_dig)
							add_digit(c);
						tok_len = 1;
						line_phase = PH_INT;
					end
				end
			end else begin
				fail_line(E_BAD_READY);
			end
		end
		PH_AFTER: begin
			if (is_end)
				close_line();
			else if (c == CH_COMMA)
				line_phase = PH_READY;
			else
				fail_line(E_BAD_AFTER);
		end
		PH_STR: begin
			if (c == CH_QUOTE) begin
				r.kind = K_STR_DONE;
				r.str_len = tok_len[7:0];
				pending_results.push_back(r);
				param_num++;
				tok_len = 0;
				line_phase = PH_AFTER;
			end else if (c < PRINT_LO || c > PRINT_HI) begin
				fail_line(E_NONPRINT);
			end else if (tok_len >= TOKEN_MAX) begin
				fail_line(E_OVERFLOW);
			end else begin
				r.str_char = c;
				r.char_pos = tok_len[6:0];
				pending_results.push_back(r);
				tok_len++;
			end
		end
		PH_INT: begin
			if (c == CH_COMMA || is_end) begin
				if (!digit_seen) begin
					fail_line(c == CH_COMMA ? E_SIGN_COMMA : E_SIGN_END);
				end else begin
					r.kind = K_INT;
					r.param_value = int_result_of();
					if (is_end) begin
						r.last = 1'b1;
						r.param_count = 5'(param_num + 1);
						line_phase = PH_IDLE;
					end else begin
						line_phase = PH_READY;
					end
					pending_results.push_back(r);
					param_num++;
					tok_len = 0;
				end
			end else if (!is_dig) begin
				fail_line(E_BAD_INT);
			end else if (tok_len >= TOKEN_MAX) begin
				fail_line(E_OVERFLOW);
			end else begin
				add_digit(c);
				tok_len++;
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= 50)
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// Result checker: every beat taken from the block is matched to the oldest
	// outstanding prediction.
	always @(posedge clk) begin : check_results
		parse_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 50)
					$display("%0t: unexpected result beat, expected none actual kind %0d",
						$time, kind);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("param_index", want.param_index, param_index);
				check_field("param_value", want.param_value, param_value);
				check_field("str_char", want.str_char, str_char);
				check_field("char_pos", want.char_pos, char_pos);
				check_field("str_len", want.str_len, str_len);
				check_field("last", want.last, last);
				check_field("param_count", want.param_count, param_count);
				check_field("error_code", want.error_code, error_code);
			end
		end
	end

	// Receiver: a long hold-off overrides the random stall rate while it lasts.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_beat(input logic is_start, input logic [7:0] c);
		@(negedge clk);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		op <= is_start;
		char_in <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		parse_char(is_start, c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(1'b0, s[i]);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_error_line(input string s, input logic [7:0] tail);
		send_beat(1'b1, 8'($urandom_range(255)));
		send_text(s);
		send_beat(1'b0, tail);
	endtask

	// Builds one mostly well-formed line with random content; a few beats get
	// corrupted so that the error paths are reached from every phase that has them.
	task automatic send_random_line();
		logic [7:0] text[$];
		int         n_params;
		int         pick;
		int         len;
		logic       need_sep;
		logic [7:0] c;
		need_sep = 1'b0;
		repeat ($urandom_range(0, 4)) begin
			c = 8'($urandom_range(1, 255));
			text.push_back(c == CH_SPACE ? 8'h41 : c);
		end
		text.push_back(CH_SPACE);
		if ($urandom_range(99) < 5) begin
			repeat ($urandom_range(1, 10))
				text.push_back(8'($urandom_range(255)));
		end else begin
			n_params = ($urandom_range(99) < 8) ? $urandom_range(14, 18) : $urandom_range(0, 5);
			for (int p = 0; p < n_params; p++) begin
				if (need_sep)
					text.push_back(CH_COMMA);
				pick = $urandom_range(19);
				if (pick < 4) begin
					text.push_back(CH_COMMA);
					need_sep = 1'b0;
				end else if (pick < 12) begin
					case ($urandom_range(2))
					1: text.push_back(CH_PLUS);
					2: text.push_back(CH_MINUS);
					default: ;
					endcase
					if ($urandom_range(99) < 5)
						len = $urandom_range(TOKEN_MAX - 3, TOKEN_MAX + 2);
					else if (text[$] != CH_COMMA && text[$] != CH_SPACE
							&& $urandom_range(99) < 4)
						len = 0;
					else
						len = $urandom_range(1, 12);
					repeat (len)
						text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
					need_sep = 1'b1;
				end else begin
					text.push_back(CH_QUOTE);
					len = ($urandom_range(99) < 5) ? $urandom_range(TOKEN_MAX - 2, TOKEN_MAX + 2)
						: $urandom_range(0, 8);
					repeat (len) begin
						c = 8'($urandom_range(PRINT_LO, PRINT_HI));
						text.push_back(c == CH_QUOTE ? 8'h71 : c);
					end
					text.push_back(CH_QUOTE);
					need_sep = 1'b1;
				end
			end
			case ($urandom_range(2))
			0: text.push_back(CH_NUL);
			1: text.push_back(CH_CR);
			default: text.push_back(CH_LF);
			endcase
		end
		send_beat(1'b1, 8'($urandom_range(255)));
		foreach (text[i]) begin
			c = text[i];
			if ($urandom_range(999) < 8)
				c = 8'($urandom_range(255));
			send_beat(1'b0, c);
		end
		// Extra bytes may follow; the parser ignores any that come after the end of the line.
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(1, 2))
				send_beat(1'b0, 8'($urandom_range(255)));
	endtask

	task automatic random_lines(input int n_beats);
		int stop_at;
		stop_at = beats_sent + n_beats;
		while (beats_sent < stop_at)
			send_random_line();
	endtask

	task automatic test_line_basics();
		send_beat(1'b0, "Z");
		send_beat(1'b1, 8'hFF);
		send_text("+R: ,\"~ \",-99999999999,+0");
		send_beat(1'b0, CH_CR);
		send_beat(1'b0, "x");
		send_beat(1'b1, 8'h00);
		send_beat(1'b0, CH_LF);
		send_beat(1'b0, CH_CR);
		send_beat(1'b0, CH_NUL);
		send_beat(1'b1, 8'h5A);
		send_text("A: 2147483648,\"\"");
		send_beat(1'b0, CH_LF);
		// A start in the middle of a string abandons it.
		send_beat(1'b1, 8'h01);
		send_text(" \"ab");
		send_beat(1'b1, 8'h80);
		send_text(" ,,");
		send_beat(1'b0, CH_NUL);
		wait_drained();
	endtask

	task automatic test_error_codes();
		send_error_line("X ", CH_SPACE);
		send_error_line(" ", "x");
		send_error_line(" \"a\"", "b");
		send_error_line(" \"", 8'h7F);
		send_error_line(" \"", 8'h1F);
		send_error_line(" +", CH_COMMA);
		send_error_line(" -", CH_LF);
		send_error_line(" 1", "z");
		wait_drained();
	endtask

	task automatic test_random_free_flow();
		send_idle_pct = 0;
		stall_pct = 0;
		random_lines(300);
		wait_drained();
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct = 73;
		stall_pct = 0;
		random_lines(300);
		wait_drained();
	endtask

	task automatic test_random_receiver_stalls();
		send_idle_pct = 0;
		stall_pct = 73;
		random_lines(300);
		wait_drained();
	endtask

	task automatic test_random_mixed_gaps();
		send_idle_pct = 11;
		stall_pct = 11;
		random_lines(300);
		wait_drained();
	endtask

	// The receiver holds off long enough for both pipeline registers to fill
	// while a long string keeps the input side busy.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 300;
		send_beat(1'b1, 8'h00);
		send_text(" \"");
		repeat (60)
			send_beat(1'b0, 8'($urandom_range(CH_ZERO, 8'h7A)));
		send_beat(1'b0, CH_QUOTE);
		send_beat(1'b0, CH_CR);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 0;
		stall_pct = 30;
		repeat (4) begin
			send_random_line();
			wait_drained();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_line_basics();
		test_error_codes();
		test_random_free_flow();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_mixed_gaps();
		test_backpressure();
		test_drain_pause();
		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
